### design/dlq_pkg.sv
// ----------------------------------------------------------------------------
// dlq_pkg
// Shared types and constants of the dynamic linear quantizer to unsigned 8-bit.
// ----------------------------------------------------------------------------
package dlq_pkg;

  // default geometry of a sample: signed fixed point
  localparam int unsigned SAMPLE_WIDTH_DEF  = 16;
  localparam int unsigned FRACTION_BITS_DEF = 8;

  // result geometry
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned SCALE_W  = 17;
  localparam int unsigned CODE_MAX = 255;

  // quotient bits worked out for a code or a zero point; larger saturates
  localparam int unsigned CODE_QBITS = 10;

  // what an input word asks for
  typedef enum logic {
    ACT_MEASURE  = 1'b0,
    ACT_QUANTIZE = 1'b1
  } dlq_action_e;

  // divider status towards the sequencer
  typedef struct packed {
    logic done;
    logic ovf;
  } dlq_div_stat_t;

endpackage

### design/dlq_stream_if.sv
// ----------------------------------------------------------------------------
// dlq_stream_if
// Valid/ready channels of the quantizer: sample words in, code words out.
// ----------------------------------------------------------------------------
interface dlq_in_if #(
  parameter int unsigned SW = 16
);
  logic          valid;
  logic          ready;
  logic          action;
  logic          first;
  logic [SW-1:0] sample;

  modport source (output valid, action, first, sample, input ready);
  modport sink   (input valid, action, first, sample, output ready);
endinterface

interface dlq_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  code;
  logic [7:0]  zero_point;
  logic [16:0] scale_fixed;

  modport source (output valid, code, zero_point, scale_fixed, input ready);
  modport sink   (input valid, code, zero_point, scale_fixed, output ready);
endinterface

### design/dlq_range.sv
// ----------------------------------------------------------------------------
// dlq_range
// Running minimum and maximum of measured samples, zero always in range.
// ----------------------------------------------------------------------------
module dlq_range #(
  parameter int unsigned SW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          upd_i,
  input  logic          first_i,
  input  logic [SW-1:0] sample_i,
  output logic [SW-1:0] span_o,
  output logic [SW-1:0] nmin_o
);

  logic signed [SW-1:0] min_q, max_q;
  logic signed [SW-1:0] base_min, base_max, smp;
  logic        [SW:0]   diff;

  assign smp = $signed(sample_i);

  // a first word restarts both bounds at zero
  assign base_min = first_i ? '0 : min_q;
  assign base_max = first_i ? '0 : max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '0;
    end else if (upd_i) begin
      min_q <= (smp < base_min) ? smp : base_min;
      max_q <= (smp > base_max) ? smp : base_max;
    end
  end

  // span and negated minimum, both non-negative and fitting SW bits
  assign diff   = {max_q[SW-1], max_q} - {min_q[SW-1], min_q};
  assign span_o = diff[SW-1:0];
  assign nmin_o = ~min_q + 1'b1;

endmodule

### design/dlq_divider.sv
// ----------------------------------------------------------------------------
// dlq_divider
// Shared restoring divider, one quotient bit per cycle, with quotient overflow
// flag for results that only need their low bits.
// ----------------------------------------------------------------------------
module dlq_divider
  import dlq_pkg::*;
#(
  parameter int unsigned RW    = 34,
  parameter int unsigned QW    = 26,
  parameter int unsigned CNT_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RW-1:0]    num_i,
  input  logic [RW-1:0]    den_i,   // divisor already aligned to the top quotient bit
  input  logic [CNT_W-1:0] steps_i,
  output logic [QW-1:0]    quo_o,
  output dlq_div_stat_t    stat_o
);

  logic [RW-1:0]    rem_q, dsh_q;
  logic [QW-1:0]    quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q, ovf_q;
  logic             fits;

  assign fits = (rem_q >= dsh_q);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: trial subtract and shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= den_i;
      quo_q <= '0;
      ovf_q <= ({1'b0, num_i} >= {den_i, 1'b0});
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QW-2:0], fits};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign quo_o       = quo_q;
  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;

endmodule

### design/dynamic_linear_quantizer_u8.sv
// ----------------------------------------------------------------------------
// dynamic_linear_quantizer_u8
// Two-pass dynamic linear quantizer of signed fixed-point samples to uint8.
// ----------------------------------------------------------------------------
// in_i carries sample words: a measure word (action 0) folds the sample into
// the running minimum and maximum, a set first bit restarting both at zero; it
// gives no result and ready stays high. A quantize word (action 1) gives one
// word on out_o: code, zero point and scale span/255 in units of 2^-16.
// All divisions go through one shared restoring divider, one quotient bit a
// cycle, and ready is low while a quantize word is in work. Zero point and
// scale are kept and only worked out again after a measure word or reset:
//   quantize, no measure since : code division only
//   first quantize after a measure : zero point, scale and code divisions
//   zero span : no division, result straight to the output (all fields zero)
// A finished result waits in the output register; a new quantize word can be
// accepted meanwhile, but its result is held back until the old one is taken.
// Reset clears minimum and maximum to zero and empties the output register.
// ----------------------------------------------------------------------------
module dynamic_linear_quantizer_u8
  import dlq_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dlq_in_if.sink    in_i,
  dlq_out_if.source out_o
);

  localparam int unsigned SW          = SAMPLE_WIDTH;
  localparam int unsigned RW          = SW + 18;
  localparam int unsigned QW          = SW + 10;
  localparam int unsigned CNT_W       = $clog2(QW + 1);
  localparam int unsigned SCALE_STEPS = SW + 10 - FRACTION_BITS;
  localparam int unsigned SCALE_SHIFT = 17 - FRACTION_BITS;
  localparam logic [RW-1:0] DEN_SCALE = RW'(2 * CODE_MAX) << (SCALE_STEPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZP,
    ST_SCALE,
    ST_CODE,
    ST_DONE
  } state_e;

  state_e        state_q;
  logic          stale_q, zero_q, out_valid_q;
  logic [SW-1:0] sample_q;
  logic [7:0]    zp_q, res_code_q, out_code_q, out_zp_q;
  logic [16:0]   scale_q, out_scale_q;

  logic          acc, acc_quant, acc_measure, span_zero;
  logic [SW-1:0] span, nmin, x_cur, mag, n_sel;
  logic          div_start;
  logic [RW-1:0] div_num, div_den, num_code, rn;
  logic [CNT_W-1:0] div_steps;
  logic [QW-1:0] div_quo;
  dlq_div_stat_t div_stat;
  logic [CODE_QBITS-1:0] q;
  logic [CODE_QBITS:0]   sum;
  logic [7:0]    zp_calc, code_calc;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign acc         = in_i.valid && in_i.ready;
  assign acc_quant   = acc && (in_i.action == ACT_QUANTIZE);
  assign acc_measure = acc && (in_i.action == ACT_MEASURE);

  dlq_range #(.SW(SW)) u_range (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (acc_measure),
    .first_i  (in_i.first),
    .sample_i (in_i.sample),
    .span_o   (span),
    .nmin_o   (nmin)
  );

  assign span_zero = (span == '0);

  // magnitude of the sample in work: the arriving word while idle
  assign x_cur = (state_q == ST_IDLE) ? in_i.sample : sample_q;
  assign mag   = x_cur[SW-1] ? (~x_cur + 1'b1) : x_cur;

  // numerator 2*n*255 + span, as 512n - 2n + span
  assign rn       = RW'(n_sel);
  assign num_code = (rn << 9) - (rn << 1) + RW'(span);

  // divider launch and operand selection
  always_comb begin
    div_start = 1'b0;
    n_sel     = mag;
    div_num   = num_code;
    div_den   = RW'(span) << CODE_QBITS;
    div_steps = CNT_W'(CODE_QBITS);
    unique case (state_q)
      ST_IDLE: begin
        if (acc_quant && !span_zero) begin
          div_start = 1'b1;
          n_sel     = stale_q ? nmin : mag;
        end
      end
      ST_ZP: begin
        if (div_stat.done) begin
          div_start = 1'b1;
          div_num   = (RW'(span) << SCALE_SHIFT) + RW'(CODE_MAX);
          div_den   = DEN_SCALE;
          div_steps = CNT_W'(SCALE_STEPS);
        end
      end
      ST_SCALE: begin
        div_start = div_stat.done;
      end
      ST_CODE, ST_DONE: begin
        div_start = 1'b0;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  dlq_divider #(.RW(RW), .QW(QW), .CNT_W(CNT_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .steps_i (div_steps),
    .quo_o   (div_quo),
    .stat_o  (div_stat)
  );

  // zero point clamps, code adds the signed quotient and saturates
  assign q       = div_quo[CODE_QBITS-1:0];
  assign zp_calc = (q > CODE_QBITS'(CODE_MAX)) ? 8'(CODE_MAX) : q[7:0];
  assign sum     = (CODE_QBITS + 1)'(zp_q) + (CODE_QBITS + 1)'(q);

  always_comb begin
    if (sample_q[SW-1]) begin
      if (div_stat.ovf || (q > CODE_QBITS'(zp_q))) begin
        code_calc = '0;
      end else begin
        code_calc = zp_q - q[7:0];
      end
    end else begin
      if (div_stat.ovf || (sum > (CODE_QBITS + 1)'(CODE_MAX))) begin
        code_calc = 8'(CODE_MAX);
      end else begin
        code_calc = sum[7:0];
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stale_q     <= 1'b1;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
      zero_q      <= 1'b0;
      zp_q        <= '0;
      res_code_q  <= '0;
      scale_q     <= '0;
      out_code_q  <= '0;
      out_zp_q    <= '0;
      out_scale_q <= '0;
    end else begin
      // a taken word empties the output register unless a new one loads
      if (out_valid_q && out_o.ready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      if (acc_measure) begin
        stale_q <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (acc_quant) begin
            sample_q <= in_i.sample;
            zero_q   <= span_zero;
            if (span_zero) begin
              state_q <= ST_DONE;
            end else if (stale_q) begin
              state_q <= ST_ZP;
            end else begin
              state_q <= ST_CODE;
            end
          end
        end
        ST_ZP: begin
          if (div_stat.done) begin
            zp_q    <= zp_calc;
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (div_stat.done) begin
            scale_q <= div_quo[16:0];
            stale_q <= 1'b0;
            state_q <= ST_CODE;
          end
        end
        ST_CODE: begin
          if (div_stat.done) begin
            res_code_q <= code_calc;
            state_q    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_code_q  <= zero_q ? '0 : res_code_q;
            out_zp_q    <= zero_q ? '0 : zp_q;
            out_scale_q <= zero_q ? '0 : scale_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.code        = out_code_q;
  assign out_o.zero_point  = out_zp_q;
  assign out_o.scale_fixed = out_scale_q;

endmodule

### design/dlq_checker.sv
// ----------------------------------------------------------------------------
// dlq_checker
// Port-level checks of the quantizer, bound to the top level.
// ----------------------------------------------------------------------------
module dlq_checker
  import dlq_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_action_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_code_i,
  input logic [7:0]  out_zero_point_i,
  input logic [16:0] out_scale_fixed_i
);

  // a quantize word occupies the block
  a_quant_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_action_i == ACT_QUANTIZE)) |=> !in_ready_i)
    else $error("ready still high after a quantize word");

  // a measure word leaves the block free
  a_measure_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_action_i == ACT_MEASURE)) |=> in_ready_i)
    else $error("ready dropped after a measure word");

  // a new result only appears at the end of a quantize word
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared while idle");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_code_i)
      && $stable(out_zero_point_i) && $stable(out_scale_fixed_i)))
    else $error("stalled result word changed");

endmodule

bind dynamic_linear_quantizer_u8 dlq_checker u_dlq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_action_i       (in_i.action),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_code_i        (out_o.code),
  .out_zero_point_i  (out_o.zero_point),
  .out_scale_fixed_i (out_o.scale_fixed)
);

### dv/tb_dynamic_linear_quantizer_u8.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dynamic_linear_quantizer_u8
// Self-checking bench for the two-pass uint8 quantizer. Tensors of measure
// words build a range, then quantize words are checked against a predictor
// of min/max tracking, zero point, code rounding and scale, under random
// idling on both sides of the block.
// ----------------------------------------------------------------------------
module tb_dynamic_linear_quantizer_u8;
  import dlq_pkg::*;

  localparam longint CodeMax    = longint'(CODE_MAX);
  localparam int     ScaleShift = 16 - FRACTION_BITS_DEF;
  localparam int     WatchLimit = 4000;
  localparam int     DrainWait  = 64;
  localparam int     PhaseWords = 300;

  typedef struct {
    logic [CODE_W-1:0]  code;
    logic [CODE_W-1:0]  zero_point;
    logic [SCALE_W-1:0] scale_fixed;
  } quant_word_t;

  // expected code words and the predictor that produces them
  class quant_scoreboard;
    logic signed [SAMPLE_WIDTH_DEF-1:0] run_min;
    logic signed [SAMPLE_WIDTH_DEF-1:0] run_max;
    quant_word_t pending[$];
    int unsigned errors;
    int unsigned n_measure;
    int unsigned n_quantize;
    int unsigned n_checked;
    int unsigned n_zero_span;
    int unsigned n_saturated;

    function new();
      run_min = '0;
      run_max = '0;
      errors = 0;
      n_measure = 0;
      n_quantize = 0;
      n_checked = 0;
      n_zero_span = 0;
      n_saturated = 0;
    endfunction

    // fold a measure word into the range, or predict the code of a quantize word
    function void note_input(dlq_action_e act, logic first,
                             logic signed [SAMPLE_WIDTH_DEF-1:0] x);
      longint span, zp, mag, q, val, xs;
      quant_word_t w;
      if (act == ACT_MEASURE) begin
        n_measure++;
        if (first) begin
          run_min = '0;
          run_max = '0;
        end
        if (x < run_min) run_min = x;
        if (x > run_max) run_max = x;
        return;
      end
      n_quantize++;
      span = longint'(run_max) - longint'(run_min);
      if (span == 0) begin
        n_zero_span++;
        w.code = '0;
        w.zero_point = '0;
        w.scale_fixed = '0;
        pending.push_back(w);
        return;
      end
      // zero point and code both use round half away from zero
      zp = (2 * (-longint'(run_min)) * CodeMax + span) / (2 * span);
      if (zp > CodeMax) zp = CodeMax;
      xs = longint'(x);
      mag = (xs < 0) ? -xs : xs;
      q = (2 * mag * CodeMax + span) / (2 * span);
      val = (xs < 0) ? zp - q : zp + q;
      if (val < 0) val = 0;
      else if (val > CodeMax) val = CodeMax;
      if (val == 0 || val == CodeMax) n_saturated++;
      w.code = val[CODE_W-1:0];
      w.zero_point = zp[CODE_W-1:0];
      w.scale_fixed = SCALE_W'((((span << ScaleShift) * 2) + CodeMax) / (2 * CodeMax));
      pending.push_back(w);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [CODE_W-1:0] code, logic [CODE_W-1:0] zero_point,
                      logic [SCALE_W-1:0] scale_fixed);
      quant_word_t w;
      if (pending.size() == 0) begin
        report($sformatf("code word %0d/%0d/%0d with none expected",
                         code, zero_point, scale_fixed));
        return;
      end
      w = pending.pop_front();
      n_checked++;
      if (code !== w.code)
        report($sformatf("code %0d, expected %0d", code, w.code));
      if (zero_point !== w.zero_point)
        report($sformatf("zero_point %0d, expected %0d", zero_point, w.zero_point));
      if (scale_fixed !== w.scale_fixed)
        report($sformatf("scale_fixed %0d, expected %0d", scale_fixed, w.scale_fixed));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  dlq_in_if #(.SW(SAMPLE_WIDTH_DEF)) in_if ();
  dlq_out_if out_if ();

  dynamic_linear_quantizer_u8 dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  quant_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int words_sent;
  int stim_lo;
  int stim_hi;
  int idle_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // monitors: check taken code words, note accepted sample words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.code, out_if.zero_point, out_if.scale_fixed);
      if (in_if.valid && in_if.ready)
        sb.note_input(dlq_action_e'(in_if.action), in_if.first, in_if.sample);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("watchdog: no handshake for %0d cycles", WatchLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // one sample word, with random gaps ahead of it
  task send_word(dlq_action_e act, logic first, logic signed [SAMPLE_WIDTH_DEF-1:0] x);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.first  <= first;
    in_if.sample <= x;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
    // keep the range the stimulus aims its quantize samples at
    if (act == ACT_MEASURE) begin
      if (first) begin
        stim_lo = 0;
        stim_hi = 0;
      end
      if (int'(x) < stim_lo) stim_lo = int'(x);
      if (int'(x) > stim_hi) stim_hi = int'(x);
    end
  endtask

  // random sample of a given signed width
  function automatic logic signed [SAMPLE_WIDTH_DEF-1:0] rand_sample(int k);
    logic signed [SAMPLE_WIDTH_DEF-1:0] t;
    t = SAMPLE_WIDTH_DEF'($urandom);
    t = t <<< (SAMPLE_WIDTH_DEF - k);
    t = t >>> (SAMPLE_WIDTH_DEF - k);
    return t;
  endfunction

  // measure pass then quantize pass over one tensor
  task run_tensor();
    int k, n_meas, n_q, pick;
    logic signed [SAMPLE_WIDTH_DEF-1:0] x;
    k = $urandom_range(1, SAMPLE_WIDTH_DEF);
    n_meas = $urandom_range(1, 12);
    n_q = $urandom_range(1, 10);
    for (int i = 0; i < n_meas; i++) begin
      // now and then the range carries over from the previous tensor
      send_word(ACT_MEASURE, (i == 0) && ($urandom_range(7) != 0), rand_sample(k));
    end
    for (int i = 0; i < n_q; i++) begin
      pick = $urandom_range(9);
      if (pick < 7)
        x = SAMPLE_WIDTH_DEF'(stim_lo + $urandom_range(stim_hi - stim_lo));
      else if (pick < 9)
        x = rand_sample(k);
      else
        x = SAMPLE_WIDTH_DEF'($urandom);
      send_word(ACT_QUANTIZE, 1'($urandom_range(1)), x);
    end
  endtask

  // directed: extremes, zero span, saturation, half rounding
  task run_directed();
    send_word(ACT_QUANTIZE, 1'b1, 16'sd0);
    send_word(ACT_QUANTIZE, 1'b0, -16'sd32768);
    send_word(ACT_MEASURE, 1'b1, 16'sd32767);
    send_word(ACT_MEASURE, 1'b0, -16'sd32768);
    send_word(ACT_QUANTIZE, 1'b0, -16'sd32768);
    send_word(ACT_QUANTIZE, 1'b0, 16'sd32767);
    send_word(ACT_QUANTIZE, 1'b0, 16'sd0);
    send_word(ACT_QUANTIZE, 1'b1, 16'sd1);
    send_word(ACT_QUANTIZE, 1'b0, -16'sd1);
    // restart at zero: zero span again
    send_word(ACT_MEASURE, 1'b1, 16'sd0);
    send_word(ACT_QUANTIZE, 1'b0, 16'sd100);
    // positive-only range, samples outside it saturate
    send_word(ACT_MEASURE, 1'b1, 16'sd256);
    send_word(ACT_QUANTIZE, 1'b0, 16'sd256);
    send_word(ACT_QUANTIZE, 1'b0, -16'sd5);
    send_word(ACT_QUANTIZE, 1'b1, 16'sd32767);
    // smallest span
    send_word(ACT_MEASURE, 1'b1, -16'sd1);
    send_word(ACT_QUANTIZE, 1'b0, -16'sd1);
    send_word(ACT_QUANTIZE, 1'b0, 16'sd1);
    // span 2: zero point and codes land on exact halves
    send_word(ACT_MEASURE, 1'b1, 16'sd1);
    send_word(ACT_MEASURE, 1'b0, -16'sd1);
    send_word(ACT_QUANTIZE, 1'b0, -16'sd1);
    send_word(ACT_QUANTIZE, 1'b0, 16'sd1);
    send_word(ACT_QUANTIZE, 1'b0, 16'sd0);
  endtask

  // main sequence
  initial begin
    int target;
    sb = new();
    tx_idle_pct = 31;
    rx_idle_pct = 60;
    words_sent = 0;
    stim_lo = 0;
    stim_hi = 0;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.action <= ACT_MEASURE;
    in_if.first <= 1'b0;
    in_if.sample <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 60 : 0;
      rx_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 31 : 0;
      target = words_sent + PhaseWords;
      if (ph == 0) run_directed();
      while (words_sent < target) begin
        if ($urandom_range(9) == 0)
          send_word(dlq_action_e'($urandom_range(1)), 1'($urandom_range(1)),
                    SAMPLE_WIDTH_DEF'($urandom));
        else
          run_tensor();
      end
    end
    in_if.valid <= 1'b0;

    // drain, then let any stray word show up
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("covered %0d measure and %0d quantize words over three idling phases",
             sb.n_measure, sb.n_quantize);
    $display("checked %0d code words: %0d with zero span, %0d clamped to 0 or 255",
             sb.n_checked, sb.n_zero_span, sb.n_saturated);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
